@@ rtl/core/cflvc_pkg.sv @@
// Shared types, constants and a helper function of the CAN frame last-value cache.
`default_nettype none

package cflvc_pkg;

   // Default number of identifiers that the table can hold.
   localparam int TABLE_DEPTH_DEFAULT = 64;

   // Field widths of one received frame.
   localparam int ID_WIDTH      = 32;
   localparam int LENGTH_WIDTH  = 4;
   localparam int PAYLOAD_WIDTH = 64;

   // Field widths of one result.
   localparam int INDEX_OUT_WIDTH = 7;
   localparam int TOTAL_OUT_WIDTH = 7;

   // Stream data widths, packed fields rounded up to whole bytes.
   localparam int REQ_DATA_WIDTH = 104;
   localparam int RSP_DATA_WIDTH = 24;

   // Largest meaningful data length; longer codes saturate to it.
   localparam logic [LENGTH_WIDTH-1:0] MAX_LENGTH = 4'd8;

   // One table entry as it sits in the entry memory.
   typedef struct packed {
      logic                     dirty;
      logic [PAYLOAD_WIDTH-1:0] payload;
      logic [LENGTH_WIDTH-1:0]  length;
      logic [ID_WIDTH-1:0]      id;
   } entry_type;

   // Mask that covers the first len payload bytes (len already saturated).
   function automatic logic [PAYLOAD_WIDTH-1:0] byte_mask(input logic [LENGTH_WIDTH-1:0] len);
      logic [PAYLOAD_WIDTH-1:0] mask;
      mask = '0;
      for (int b = 0; b < PAYLOAD_WIDTH / 8; b++) begin
         mask[8*b +: 8] = (LENGTH_WIDTH'(b) < len) ? 8'hFF : 8'h00;
      end
      return mask;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/can_frame_last_value_cache_top.sv @@
// Top level of the CAN frame last-value cache: sorted identifier table with binary search.
//
// Channel   Direction  Beat contents
// req_*     in         one received frame: identifier, data length, payload
// rsp_*     out        slot index, new / changed / full flags, entry total
//
// Each frame is handled alone by a small sequencer around one identifier comparator
// and a single-port-write, single-port-read entry memory with a registered read.
// A found or dropped frame needs only the search and the check; an inserted frame also
// moves every entry above its slot up by one, and the one-entry-per-cycle shift through
// the memory sets the worst case.
// A synchronous reset empties the table at once; stored entries need no clearing.
// A stalled result waits in its output register; the next frame may still be taken and
// searched, but it holds in its closing step until that register is free.
`default_nettype none

module can_frame_last_value_cache_top #(
   parameter int TABLE_DEPTH = cflvc_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Frame channel.
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // Fields from bit 0: frame_id[31:0], data_length[35:32], payload[99:36], zero fill.
   input  wire logic [cflvc_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   // Result channel.
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // Fields from bit 0: entry_index[6:0], is_new[7], changed[8], table_full[9],
   // entry_total[16:10], zero fill.
   output logic [cflvc_pkg::RSP_DATA_WIDTH-1:0]      rsp_tdata
);

   import cflvc_pkg::*;

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SEARCH = 7'b0000010,
      S_PROBE  = 7'b0000100,
      S_CHECK  = 7'b0001000,
      S_PRIME  = 7'b0010000,
      S_SHIFT  = 7'b0100000,
      S_FINISH = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // Frame under work.
   logic [ID_WIDTH-1:0]      key_ff, key_in;
   logic [LENGTH_WIDTH-1:0]  len_ff, len_in;
   logic [PAYLOAD_WIDTH-1:0] data_ff, data_in;

   // Search window, probe point, shift pointer and fill count.
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] mid_calc;

   // Result under construction.
   logic [CW-1:0] res_index_ff, res_index_in;
   logic          res_new_ff, res_new_in;
   logic          res_changed_ff, res_changed_in;
   logic          res_full_ff, res_full_in;

   // Output register.
   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata_ff, rsp_tdata_in;

   // Entry memory ports.
   entry_type          entry_mem [TABLE_DEPTH];
   entry_type          rd_data_ff;
   logic [IW-1:0]      rd_addr;
   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   entry_type          wr_data;
   entry_type          new_entry;
   logic               id_less;
   logic               id_equal;
   logic               content_differs;
   logic               table_is_full;
   logic [LENGTH_WIDTH-1:0] req_len_raw;

   // Shared identifier comparator and content compare on the registered read data.
   assign id_less         = rd_data_ff.id < key_ff;
   assign id_equal        = rd_data_ff.id == key_ff;
   assign content_differs = (rd_data_ff.length != len_ff) ||
                            (((rd_data_ff.payload ^ data_ff) & byte_mask(len_ff)) != '0);
   assign table_is_full   = count_ff >= CW'(TABLE_DEPTH);
   assign mid_calc        = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign req_len_raw     = req_tdata[ID_WIDTH +: LENGTH_WIDTH];

   assign new_entry.dirty   = 1'b1;
   assign new_entry.payload = data_ff;
   assign new_entry.length  = len_ff;
   assign new_entry.id      = key_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Sequencer: search, check, then overwrite, drop or shift-and-insert.
   always_comb begin
      state_in       = state_ff;
      key_in         = key_ff;
      len_in         = len_ff;
      data_in        = data_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      mid_in         = mid_ff;
      k_in           = k_ff;
      count_in       = count_ff;
      res_index_in   = res_index_ff;
      res_new_in     = res_new_ff;
      res_changed_in = res_changed_ff;
      res_full_in    = res_full_ff;
      rsp_tvalid_in  = rsp_tvalid_ff;
      rsp_tdata_in   = rsp_tdata_ff;
      rd_addr        = IW'(lo_ff);
      wr_en          = 1'b0;
      wr_addr        = IW'(lo_ff);
      wr_data        = new_entry;

      // The output register empties when its beat is taken.
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               key_in         = req_tdata[ID_WIDTH-1:0];
               len_in         = (req_len_raw > MAX_LENGTH) ? MAX_LENGTH : req_len_raw;
               data_in        = req_tdata[ID_WIDTH+LENGTH_WIDTH +: PAYLOAD_WIDTH];
               lo_in          = '0;
               hi_in          = count_ff;
               res_new_in     = 1'b0;
               res_changed_in = 1'b0;
               res_full_in    = 1'b0;
               state_in       = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               rd_addr  = IW'(mid_calc);
               mid_in   = mid_calc;
               state_in = S_PROBE;
            end else if (lo_ff < count_ff) begin
               rd_addr  = IW'(lo_ff);
               state_in = S_CHECK;
            end else if (table_is_full) begin
               res_index_in = CW'(TABLE_DEPTH);
               res_full_in  = 1'b1;
               state_in     = S_FINISH;
            end else begin
               state_in = S_PRIME;
            end
         end
         S_PROBE: begin
            if (id_less) begin
               lo_in = mid_ff + CW'(1);
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_SEARCH;
         end
         S_CHECK: begin
            if (id_equal) begin
               res_index_in = lo_ff;
               if (content_differs) begin
                  wr_en          = 1'b1;
                  wr_addr        = IW'(lo_ff);
                  wr_data        = new_entry;
                  res_changed_in = 1'b1;
               end
               state_in = S_FINISH;
            end else if (table_is_full) begin
               res_index_in = CW'(TABLE_DEPTH);
               res_full_in  = 1'b1;
               state_in     = S_FINISH;
            end else begin
               state_in = S_PRIME;
            end
         end
         S_PRIME: begin
            // Fetch the top entry, the first to move up.
            rd_addr  = IW'(count_ff - CW'(1));
            k_in     = count_ff;
            state_in = S_SHIFT;
         end
         S_SHIFT: begin
            if (k_ff > lo_ff) begin
               // Move entry k-1 to k and fetch the one below it.
               wr_en   = 1'b1;
               wr_addr = IW'(k_ff);
               wr_data = rd_data_ff;
               rd_addr = IW'(k_ff - CW'(2));
               k_in    = k_ff - CW'(1);
            end else begin
               wr_en        = 1'b1;
               wr_addr      = IW'(lo_ff);
               wr_data      = new_entry;
               count_in     = count_ff + CW'(1);
               res_index_in = lo_ff;
               res_new_in   = 1'b1;
               state_in     = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {
                  (RSP_DATA_WIDTH - INDEX_OUT_WIDTH - 3 - TOTAL_OUT_WIDTH)'(0),
                  TOTAL_OUT_WIDTH'(count_ff),
                  res_full_ff,
                  res_changed_ff,
                  res_new_ff,
                  INDEX_OUT_WIDTH'(res_index_ff)
               };
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      len_ff         <= len_in;
      data_ff        <= data_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      mid_ff         <= mid_in;
      k_ff           <= k_in;
      res_index_ff   <= res_index_in;
      res_new_ff     <= res_new_in;
      res_changed_ff <= res_changed_in;
      res_full_ff    <= res_full_in;
      rsp_tdata_ff   <= rsp_tdata_in;
   end

   // Entry memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

`ifndef NO_ASSERTIONS
   // The search window stays inside the filled part of the table.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (lo_ff <= hi_ff && hi_ff <= count_ff))
      else $error("search window out of order");

   // Entries only move up while there is room for one more.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (count_ff < CW'(TABLE_DEPTH) && k_ff >= lo_ff))
      else $error("shift outside the table");

   // Placing a new entry grows the table by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && k_ff == lo_ff) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("fill count not advanced on insert");

   // A result appears only from the closing step of a frame.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> ($past(state_ff) == S_FINISH))
      else $error("result raised outside the closing step");

   // The fill count never exceeds the table size.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) |-> (count_ff <= CW'(TABLE_DEPTH)))
      else $error("fill count beyond table size");
`endif

endmodule

`default_nettype wire
